### sv/l2s_pkg.sv
package l2s_pkg;

    localparam int VALUE_WIDTH   = 20;
    localparam int MAG_WIDTH     = VALUE_WIDTH - 1;
    localparam int CHANNEL_WIDTH = 2;
    localparam int BYTE_WIDTH    = 8;
    localparam int N_THRESH      = 1 << BYTE_WIDTH;
    localparam int LATENCY       = BYTE_WIDTH;

    localparam logic [CHANNEL_WIDTH-1:0] ALPHA_CHANNEL = 2'd3;
    localparam logic [BYTE_WIDTH-1:0]    BYTE_MAX      = 8'hFF;

    // exact threshold arithmetic, elaboration only
    localparam int WIDE_BITS    = 320;
    localparam int LINEAR_KMAX  = 10;
    localparam int LIN_SLOPE    = 658920;
    localparam int LIN_SCALE    = 100;
    localparam int POW_BASE     = 10761;
    localparam int POW_EXP      = 12;
    localparam int POW_ROOT_EXP = 5;
    localparam int THRESH_STEP  = 40;
    localparam int THRESH_OFS   = 541;

    typedef logic [N_THRESH-1:0][VALUE_WIDTH-1:0] l2s_table_t;

    typedef struct packed {
        logic [MAG_WIDTH-1:0]  mag;
        logic                  neg;
        logic                  alpha;
        logic [BYTE_WIDTH-1:0] acc;
    } l2s_word_t;

    // true when sample v meets output level k
    function automatic logic thr_pass(input logic [VALUE_WIDTH-1:0] v, input int k,
                                      input int frac);
        logic [WIDE_BITS-1:0] lhs;
        logic [WIDE_BITS-1:0] rhs;
        int j;
        lhs = '0;
        rhs = '0;
        if (k <= LINEAR_KMAX)
        begin
            lhs = WIDE_BITS'(v) * WIDE_BITS'(LIN_SLOPE);
            rhs = WIDE_BITS'(LIN_SCALE * (2 * k - 1)) << frac;
        end
        else
        begin
            lhs = WIDE_BITS'(1);
            for (j = 0; j < POW_EXP; j++)
            begin
                lhs = lhs * WIDE_BITS'(POW_BASE);
            end
            for (j = 0; j < POW_ROOT_EXP; j++)
            begin
                lhs = lhs * WIDE_BITS'(v);
            end
            rhs = WIDE_BITS'(1);
            for (j = 0; j < POW_EXP; j++)
            begin
                rhs = rhs * WIDE_BITS'(THRESH_STEP * k + THRESH_OFS);
            end
            rhs = rhs << (POW_ROOT_EXP * frac);
        end
        return (lhs >= rhs);
    endfunction

    // smallest sample reaching each level; out-of-range levels clip to 2^MAG_WIDTH
    function automatic l2s_table_t build_thresholds(input int frac);
        l2s_table_t t;
        logic [VALUE_WIDTH:0] lo;
        logic [VALUE_WIDTH:0] hi;
        logic [VALUE_WIDTH:0] mid;
        int k;
        int it;
        t = '0;
        for (k = 1; k < N_THRESH; k++)
        begin
            lo = '0;
            hi = (VALUE_WIDTH+1)'(1) << MAG_WIDTH;
            for (it = 0; it < VALUE_WIDTH; it++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (thr_pass(mid[VALUE_WIDTH-1:0], k, frac))
                    begin
                        hi = mid;
                    end
                    else
                    begin
                        lo = mid + 1'b1;
                    end
                end
            end
            t[k] = lo[VALUE_WIDTH-1:0];
        end
        return t;
    endfunction

endpackage

### sv/l2s_step.sv
module l2s_step #(
    parameter int                  BIT   = 7,
    parameter l2s_pkg::l2s_table_t TABLE = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  l2s_pkg::l2s_word_t in_word,
    output logic               out_valid,
    output l2s_pkg::l2s_word_t out_word
);
    import l2s_pkg::*;

    localparam logic [BYTE_WIDTH-1:0] STEP_BIT = BYTE_WIDTH'(1) << BIT;

    logic [BYTE_WIDTH-1:0]  cand;
    logic [VALUE_WIDTH-1:0] thr;
    logic                   valid_reg;
    logic                   valid_next;
    l2s_word_t              word_reg;
    l2s_word_t              word_next;

    always_comb
    begin
        cand      = in_word.acc | STEP_BIT;
        thr       = TABLE[cand];
        word_next = in_word;
        if ({1'b0, in_word.mag} >= thr)
        begin
            word_next.acc = cand;
        end
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### sv/linear_to_srgb_byte.sv
// Throughput: one word per cycle; a stall on a valid output word holds the whole pipe.
// Eight successive-approximation stages, each one threshold-table read and a
// 20-bit compare, resolve one output bit per stage.
// Reset (rst_n, async, active low) clears the valid bit of every stage.
module linear_to_srgb_byte #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [l2s_pkg::VALUE_WIDTH-1:0] linear_value,
    input  logic [l2s_pkg::CHANNEL_WIDTH-1:0]    channel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [l2s_pkg::BYTE_WIDTH-1:0]       encoded_byte
);
    import l2s_pkg::*;

    localparam l2s_table_t THRESH = build_thresholds(FRAC_BITS);

    l2s_word_t stage_word  [0:LATENCY];
    logic      stage_valid [0:LATENCY];
    logic      move;

    assign move     = !(stage_valid[LATENCY] && out_stall);
    assign in_stall = !move;

    always_comb
    begin
        stage_word[0].mag   = linear_value[MAG_WIDTH-1:0];
        stage_word[0].neg   = linear_value[VALUE_WIDTH-1];
        stage_word[0].alpha = (channel == ALPHA_CHANNEL);
        stage_word[0].acc   = '0;
        stage_valid[0]      = in_valid;
    end

    for (genvar i = 0; i < LATENCY; i++)
    begin : g_step
        l2s_step #(
            .BIT   (LATENCY - 1 - i),
            .TABLE (THRESH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (move),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    assign out_valid = stage_valid[LATENCY];

    always_comb
    begin
        if (stage_word[LATENCY].alpha)
        begin
            encoded_byte = BYTE_MAX;
        end
        else if (stage_word[LATENCY].neg)
        begin
            encoded_byte = '0;
        end
        else
        begin
            encoded_byte = stage_word[LATENCY].acc;
        end
    end

endmodule

### sv/l2s_checker.sv
module l2s_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic signed [l2s_pkg::VALUE_WIDTH-1:0] linear_value,
    input logic [l2s_pkg::CHANNEL_WIDTH-1:0]      channel,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [l2s_pkg::BYTE_WIDTH-1:0]         encoded_byte
);
    import l2s_pkg::*;

    localparam logic [3:0] WARM = 4'(LATENCY + 1);

    logic [3:0]         up_cnt_reg;
    logic [3:0]         up_cnt_next;
    logic [LATENCY-1:0] hold_hist_reg;
    logic [LATENCY-1:0] hold_hist_next;
    logic               hold;
    logic               acc_word;
    logic               free_run;

    assign up_cnt_next    = (up_cnt_reg == WARM) ? up_cnt_reg : up_cnt_reg + 4'd1;
    assign hold_hist_next = {hold_hist_reg[LATENCY-2:0], hold};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_cnt_reg    <= '0;
            hold_hist_reg <= '0;
        end
        else
        begin
            up_cnt_reg    <= up_cnt_next;
            hold_hist_reg <= hold_hist_next;
        end
    end

    assign hold     = out_valid && out_stall;
    assign acc_word = in_valid && !in_stall;

    // warm-up count reached and no output hold recorded in the hold history
    assign free_run = (up_cnt_reg == WARM) && (hold_hist_reg == '0);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> out_valid && $stable(encoded_byte))
        else $error("output word changed while stalled");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> hold)
        else $error("input stalled without output hold");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        free_run |-> (out_valid == $past(acc_word, LATENCY)))
        else $error("pipeline latency mismatch");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        free_run && $past(acc_word && (channel == ALPHA_CHANNEL), LATENCY)
        |-> encoded_byte == BYTE_MAX)
        else $error("alpha word not 255");

    a_negative: assert property (@(posedge clk) disable iff (!rst_n)
        free_run && $past(acc_word && linear_value[VALUE_WIDTH-1] &&
                          (channel != ALPHA_CHANNEL), LATENCY)
        |-> encoded_byte == '0)
        else $error("negative sample not 0");

endmodule

bind linear_to_srgb_byte l2s_checker u_l2s_checker (.*);
